@@ design/nft_pkg.sv @@
// Types and constants shared by the noise floor tracker modules.
// No dependencies.
package nft_pkg;

  localparam int RSSI_W = 8;

  localparam logic [RSSI_W-1:0] RSSI_NONE        = 8'hff;
  localparam logic [RSSI_W-1:0] MIN_VALID_RESET  = 8'h10;
  localparam logic [RSSI_W-1:0] TICKS_PER_RESET  = 8'd30;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic CHAN_A = 1'b0;
  localparam logic CHAN_B = 1'b1;

  localparam logic CFG_MIN_VALID_RSSI   = 1'b0;
  localparam logic CFG_TICKS_PER_UPDATE = 1'b1;

  typedef logic [RSSI_W-1:0] rssi_t;

  typedef struct packed {
    logic  cmd;
    logic  channel;
    rssi_t rssi;
  } nft_item_t;

  typedef struct packed {
    rssi_t floor_a;
    rssi_t floor_b;
    logic  updated;
  } nft_result_t;

endpackage

@@ design/nft_in_if.sv @@
// Input channel interface of the noise floor tracker: valid, ready and item.
// No dependencies.
interface nft_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic       channel;
  logic [7:0] rssi;

  modport source (output valid, cmd, channel, rssi, input ready);
  modport sink   (input valid, cmd, channel, rssi, output ready);
endinterface

@@ design/nft_out_if.sv @@
// Result channel interface of the noise floor tracker: valid, ready and result.
// No dependencies.
interface nft_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] floor_a;
  logic [7:0] floor_b;
  logic       updated;

  modport source (output valid, floor_a, floor_b, updated, input ready);
  modport sink   (input valid, floor_a, floor_b, updated, output ready);
endinterface

@@ design/nft_in_stage.sv @@
// Input register stage: holds one accepted transaction until it moves on.
// Depends on nft_pkg and nft_in_if.
module nft_in_stage
  import nft_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  nft_in_if.sink     in_if,
  input  logic       take,
  output logic       vld,
  output nft_item_t  item
);

  logic      vld_r;
  logic      vld_nxt;
  nft_item_t item_r;

  assign in_if.ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_if.valid && in_if.ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      item_r <= '{cmd: in_if.cmd, channel: in_if.channel, rssi: in_if.rssi};
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

@@ design/nft_tracker.sv @@
// Tracker state (window minimums, estimates, tick counter) and its update logic.
// Depends on nft_pkg.
module nft_tracker
  import nft_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  nft_item_t   item,
  input  rssi_t       min_valid_rssi,
  input  rssi_t       ticks_per_update,
  output nft_result_t res
);

  rssi_t tick_count_r, tick_count_nxt;
  logic  started_r, started_nxt;
  rssi_t wmin_a_r, wmin_a_nxt;
  rssi_t wmin_b_r, wmin_b_nxt;
  rssi_t est_a_r, est_a_nxt;
  rssi_t est_b_r, est_b_nxt;
  rssi_t period;
  rssi_t count_inc;
  logic [RSSI_W:0] sum_a;
  logic [RSSI_W:0] sum_b;
  logic  updated;

  assign period    = (ticks_per_update == '0) ? rssi_t'(1) : ticks_per_update;
  assign count_inc = tick_count_r + rssi_t'(1);
  assign sum_a     = {1'b0, est_a_r} + {1'b0, wmin_a_r};
  assign sum_b     = {1'b0, est_b_r} + {1'b0, wmin_b_r};

  always_comb begin
    tick_count_nxt = tick_count_r;
    started_nxt    = started_r;
    wmin_a_nxt     = wmin_a_r;
    wmin_b_nxt     = wmin_b_r;
    est_a_nxt      = est_a_r;
    est_b_nxt      = est_b_r;
    updated        = 1'b0;
    if (item.cmd == CMD_SAMPLE) begin
      if (item.rssi >= min_valid_rssi) begin
        if (item.channel == CHAN_A) begin
          if (item.rssi < wmin_a_r) begin
            wmin_a_nxt = item.rssi;
          end
        end else begin
          if (item.rssi < wmin_b_r) begin
            wmin_b_nxt = item.rssi;
          end
        end
      end
    end else begin
      if (!started_r) begin
        started_nxt    = 1'b1;
        tick_count_nxt = '0;
      end else if (count_inc >= period) begin
        updated        = 1'b1;
        tick_count_nxt = '0;
        wmin_a_nxt     = RSSI_NONE;
        wmin_b_nxt     = RSSI_NONE;
        if (est_a_r == RSSI_NONE || est_b_r == RSSI_NONE) begin
          est_a_nxt = wmin_a_r;
          est_b_nxt = wmin_b_r;
        end else begin
          est_a_nxt = sum_a[RSSI_W:1];
          est_b_nxt = sum_b[RSSI_W:1];
        end
      end else begin
        tick_count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      started_r    <= 1'b0;
      wmin_a_r     <= RSSI_NONE;
      wmin_b_r     <= RSSI_NONE;
      est_a_r      <= RSSI_NONE;
      est_b_r      <= RSSI_NONE;
    end else if (step) begin
      tick_count_r <= tick_count_nxt;
      started_r    <= started_nxt;
      wmin_a_r     <= wmin_a_nxt;
      wmin_b_r     <= wmin_b_nxt;
      est_a_r      <= est_a_nxt;
      est_b_r      <= est_b_nxt;
    end
  end

  assign res = '{floor_a: est_a_nxt, floor_b: est_b_nxt, updated: updated};

endmodule

@@ design/dual_channel_noise_floor_tracker_core.sv @@
// Dual-channel noise floor tracker, top level: configuration registers and result register.
// An accepted transaction passes the input register, then the result register, to reach
// the output channel; these two set the throughput of one transaction per cycle while the
// output is ready. Reset is synchronous and active low; it restores the registers to 16
// and 30, empties both stages and returns every estimate and window minimum to 255.
// Depends on nft_pkg, nft_in_if, nft_out_if, nft_in_stage and nft_tracker.
module dual_channel_noise_floor_tracker_core
  import nft_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  nft_in_if.sink      in_if,
  nft_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  rssi_t       min_valid_r;
  rssi_t       ticks_per_r;
  logic        out_vld_r;
  nft_result_t out_res_r;
  logic        out_adv;
  logic        s1_vld;
  nft_item_t   s1_item;
  logic        step;
  nft_result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_valid_r <= MIN_VALID_RESET;
      ticks_per_r <= TICKS_PER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_VALID_RSSI:   min_valid_r <= cfg_data;
        CFG_TICKS_PER_UPDATE: ticks_per_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_adv = !out_vld_r || out_if.ready;
  assign step    = s1_vld && out_adv;

  nft_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .take  (out_adv),
    .vld   (s1_vld),
    .item  (s1_item)
  );

  nft_tracker u_tracker (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .item             (s1_item),
    .min_valid_rssi   (min_valid_r),
    .ticks_per_update (ticks_per_r),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid   = out_vld_r;
  assign out_if.floor_a = out_res_r.floor_a;
  assign out_if.floor_b = out_res_r.floor_b;
  assign out_if.updated = out_res_r.updated;

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for dual_channel_noise_floor_tracker_core: directed and random
// transactions, random idling on both channels, and a scoreboard that predicts every result.
// Depends on nft_pkg, nft_in_if, nft_out_if and the design under test.
module tb;
  import nft_pkg::*;

  localparam int ITEMS_PER_PHASE = 240;
  localparam int PHASES          = 8;
  localparam int STALL_LIMIT     = 5000;
  localparam int MAX_REPORTED    = 10;

  class floor_scoreboard;
    rssi_t       min_valid;
    rssi_t       ticks_per;
    rssi_t       tick_count;
    bit          started;
    rssi_t       win_a;
    rssi_t       win_b;
    rssi_t       est_a;
    rssi_t       est_b;
    nft_result_t expected_floors[$];
    int          mismatches;

    function new();
      min_valid  = MIN_VALID_RESET;
      ticks_per  = TICKS_PER_RESET;
      tick_count = '0;
      started    = 1'b0;
      win_a      = RSSI_NONE;
      win_b      = RSSI_NONE;
      est_a      = RSSI_NONE;
      est_b      = RSSI_NONE;
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, rssi_t value);
      if (idx == CFG_MIN_VALID_RSSI) begin
        min_valid = value;
      end else begin
        ticks_per = value;
      end
    endfunction

    function void note_item(nft_item_t it);
      nft_result_t r;
      rssi_t       period;
      logic [8:0]  sum_a;
      logic [8:0]  sum_b;
      r.updated = 1'b0;
      if (it.cmd == CMD_SAMPLE) begin
        if (it.rssi >= min_valid) begin
          if (it.channel == CHAN_A) begin
            if (it.rssi < win_a) win_a = it.rssi;
          end else begin
            if (it.rssi < win_b) win_b = it.rssi;
          end
        end
      end else begin
        period = (ticks_per == 0) ? 8'd1 : ticks_per;
        if (!started) begin
          started    = 1'b1;
          tick_count = '0;
        end else begin
          tick_count = tick_count + 8'd1;
          if (tick_count >= period) begin
            if (est_a == RSSI_NONE || est_b == RSSI_NONE) begin
              est_a = win_a;
              est_b = win_b;
            end else begin
              sum_a = {1'b0, est_a} + {1'b0, win_a};
              sum_b = {1'b0, est_b} + {1'b0, win_b};
              est_a = sum_a[8:1];
              est_b = sum_b[8:1];
            end
            win_a      = RSSI_NONE;
            win_b      = RSSI_NONE;
            tick_count = '0;
            r.updated  = 1'b1;
          end
        end
      end
      r.floor_a = est_a;
      r.floor_b = est_b;
      expected_floors.push_back(r);
    endfunction

    function void check_result(nft_result_t got);
      nft_result_t want;
      if (expected_floors.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("Unexpected result: floor_a=%0d floor_b=%0d updated=%0d",
                   got.floor_a, got.floor_b, got.updated);
      end else begin
        want = expected_floors.pop_front();
        if (got.floor_a !== want.floor_a || got.floor_b !== want.floor_b ||
            got.updated !== want.updated) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED)
            $display("Mismatch: expected a=%0d b=%0d upd=%0d, got a=%0d b=%0d upd=%0d",
                     want.floor_a, want.floor_b, want.updated,
                     got.floor_a, got.floor_b, got.updated);
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;
  bit         steady;
  int         stall_cycles;

  floor_scoreboard sb;

  nft_in_if  in_ch();
  nft_out_if out_ch();

  dual_channel_noise_floor_tracker_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_item(nft_item_t'{in_ch.cmd, in_ch.channel, in_ch.rssi});
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(nft_result_t'{out_ch.floor_a, out_ch.floor_b, out_ch.updated});
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    stall_cycles = 0;
    @(posedge clk);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAIL dual_channel_noise_floor_tracker_core");
    $finish;
  end

  function automatic nft_item_t make_item(logic cmd, logic channel, rssi_t rssi);
    nft_item_t it;
    it.cmd     = cmd;
    it.channel = channel;
    it.rssi    = rssi;
    return it;
  endfunction

  function automatic nft_item_t random_item(rssi_t thr, int tick_pct);
    nft_item_t it;
    int        v;
    it.cmd     = ($urandom_range(99) < tick_pct) ? CMD_TICK : CMD_SAMPLE;
    it.channel = 1'($urandom_range(1));
    if ($urandom_range(1)) begin
      v = int'(thr) + int'($urandom_range(6)) - 3;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      it.rssi = v[7:0];
    end else begin
      it.rssi = rssi_t'($urandom_range(255));
    end
    return it;
  endfunction

  task automatic send_item(input nft_item_t it);
    if (!steady) begin
      while ($urandom_range(99) < 38) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= it.cmd;
    in_ch.channel <= it.channel;
    in_ch.rssi    <= it.rssi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // The block idles once every expected result has arrived and the pipeline has emptied.
  task automatic drain_floors();
    in_ch.valid <= 1'b0;
    while (sb.expected_floors.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_config(input rssi_t thr, input rssi_t period);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_VALID_RSSI;
    cfg_data  <= thr;
    @(posedge clk);
    sb.write_reg(CFG_MIN_VALID_RSSI, thr);
    cfg_index <= CFG_TICKS_PER_UPDATE;
    cfg_data  <= period;
    @(posedge clk);
    sb.write_reg(CFG_TICKS_PER_UPDATE, period);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rssi_t thr_tab[PHASES];
    rssi_t per_tab[PHASES];
    int    tick_pct;

    sb             = new();
    rst_n          = 1'b0;
    steady         = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_MIN_VALID_RSSI;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_SAMPLE;
    in_ch.channel  = CHAN_A;
    in_ch.rssi     = '0;
    out_ch.ready   = 1'b0;

    thr_tab = '{8'd16, 8'd0, 8'd255, 8'd40, 8'd0, 8'd100, 8'd1, 8'd0};
    per_tab = '{8'd30, 8'd1, 8'd2, 8'd255, 8'd0, 8'd3, 8'd8, 8'd0};
    thr_tab[4] = rssi_t'($urandom_range(255));
    thr_tab[7] = rssi_t'($urandom_range(255));
    per_tab[7] = rssi_t'($urandom_range(10, 1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Readings below and at the threshold, and a first window with only channel A valid.
    load_config(8'd16, 8'd2);
    send_item(make_item(CMD_SAMPLE, CHAN_A, 8'd0));
    send_item(make_item(CMD_SAMPLE, CHAN_B, 8'd15));
    send_item(make_item(CMD_SAMPLE, CHAN_A, 8'd16));
    send_item(make_item(CMD_SAMPLE, CHAN_A, 8'd255));
    send_item(make_item(CMD_TICK, CHAN_B, 8'd255));
    send_item(make_item(CMD_TICK, CHAN_A, 8'd0));
    send_item(make_item(CMD_TICK, CHAN_B, 8'd170));
    send_item(make_item(CMD_SAMPLE, CHAN_B, 8'd200));
    send_item(make_item(CMD_SAMPLE, CHAN_A, 8'd100));
    send_item(make_item(CMD_SAMPLE, CHAN_B, 8'd255));
    send_item(make_item(CMD_TICK, CHAN_A, 8'd85));
    send_item(make_item(CMD_TICK, CHAN_B, 8'd1));
    send_item(make_item(CMD_SAMPLE, CHAN_A, 8'd0));
    send_item(make_item(CMD_SAMPLE, CHAN_A, 8'd90));
    send_item(make_item(CMD_SAMPLE, CHAN_B, 8'd20));
    send_item(make_item(CMD_TICK, CHAN_A, 8'd0));
    send_item(make_item(CMD_TICK, CHAN_A, 8'd0));
    send_item(make_item(CMD_TICK, CHAN_B, 8'd255));
    send_item(make_item(CMD_TICK, CHAN_B, 8'd255));
    drain_floors();

    // A zero threshold accepts every reading, and a zero period behaves as one.
    load_config(8'd0, 8'd0);
    send_item(make_item(CMD_SAMPLE, CHAN_A, 8'd0));
    send_item(make_item(CMD_SAMPLE, CHAN_B, 8'd0));
    send_item(make_item(CMD_TICK, CHAN_A, 8'd0));
    send_item(make_item(CMD_TICK, CHAN_B, 8'd0));
    drain_floors();

    // Lowering the period below the running count recalculates on the next tick.
    load_config(8'd0, 8'd255);
    repeat (5) send_item(make_item(CMD_TICK, CHAN_A, 8'd0));
    drain_floors();
    load_config(8'd0, 8'd3);
    send_item(make_item(CMD_TICK, CHAN_B, 8'd128));
    drain_floors();

    for (int p = 0; p < PHASES; p++) begin
      load_config(thr_tab[p], per_tab[p]);
      steady   = (p == 2);
      tick_pct = (per_tab[p] > 20) ? 60 : 30;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 4 && i == ITEMS_PER_PHASE / 2)
          drain_floors();
        send_item(random_item(thr_tab[p], tick_pct));
      end
      drain_floors();
    end
    steady = 1'b0;

    repeat (5) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_floors.size() == 0) begin
      $display("PASS dual_channel_noise_floor_tracker_core");
    end else begin
      $display("FAIL dual_channel_noise_floor_tracker_core");
    end
    $finish;
  end

endmodule
